@@ src/hed_pkg.sv @@
package hed_pkg;

  localparam int MAX_PACKET_BYTES = 64;
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int HDR_LEN = 12;
  localparam int HEAD_LEN = 6;
  localparam int TRIM_MAX = 127;

  localparam logic [7:0] PKT_EVENT = 8'h04;
  localparam logic [7:0] PKT_VENDOR = 8'h82;
  localparam logic [7:0] EVT_LE_META = 8'h3E;
  localparam logic [7:0] EVT_DISCONNECT = 8'h05;
  localparam logic [7:0] EVT_VENDOR = 8'hFF;
  localparam logic [7:0] SUB_CONN = 8'h01;
  localparam logic [7:0] SUB_ENH_CONN = 8'h0A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [15:0] NOT_LINKED = 16'hFFFF;
  localparam logic [15:0] CCCD_NOTIFY = 16'h0001;

  typedef enum logic [3:0] {
    KIND_OTHER        = 4'd0,
    KIND_CONNECTED    = 4'd1,
    KIND_DISCONNECTED = 4'd2,
    KIND_SUBSCRIBED   = 4'd3,
    KIND_UNSUBSCRIBED = 4'd4,
    KIND_ON           = 4'd5,
    KIND_OFF          = 4'd6,
    KIND_TOGGLE       = 4'd7,
    KIND_UNKNOWN      = 4'd8,
    KIND_IGNORED      = 4'd9
  } kind_e;

  typedef enum logic {
    REG_NOTIFY  = 1'b0,
    REG_COMMAND = 1'b1
  } reg_e;

  typedef struct packed {
    logic [HDR_LEN-1:0][7:0]  hdr;
    logic [HEAD_LEN-1:0][7:0] head;
    logic [6:0]               trimmed;
    logic [POS_W-1:0]         len;
  } packet_t;

  typedef struct packed {
    logic        restart;
    logic        notify_allowed;
    logic        subscribed;
    logic [15:0] link_handle;
    logic        led_level;
    kind_e       kind;
  } result_t;

endpackage

@@ src/hed_capture.sv @@
module hed_capture import hed_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  input  logic [7:0] in_byte_i,
  output logic    in_ready_o,
  input  logic    snap_ready_i,
  output logic    snap_valid_o,
  output packet_t snap_o
);

  logic [HDR_LEN-1:0][7:0]  hdr_q, hdr_d;
  logic [HEAD_LEN-1:0][7:0] head_q, head_d;
  logic [6:0]               trim_q, trim_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [POS_W-1:0]         data_idx;
  logic [POS_W:0]           data_cnt;
  logic [15:0]              decl_len;
  logic                     snap_valid_q;
  packet_t                  snap_q;
  logic                     accept;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept = in_valid_i && in_ready_o;

  assign decl_len = (hdr_q[0] == PKT_EVENT) ? {8'h00, hdr_q[11]} : {hdr_q[11], hdr_q[10]};
  assign data_idx = pos_q - POS_W'(HDR_LEN);
  assign data_cnt = {1'b0, data_idx} + (POS_W+1)'(1);

  always_comb begin
    hdr_d = hdr_q;
    head_d = head_q;
    trim_d = trim_q;
    pos_d = pos_q;
    if (int'(pos_q) < MAX_PACKET_BYTES) begin
      if (int'(pos_q) < HDR_LEN) begin
        hdr_d[pos_q[3:0]] = in_byte_i;
      end else if (16'(data_idx) < decl_len) begin
        if (int'(data_idx) < HEAD_LEN) begin
          head_d[data_idx[2:0]] = in_byte_i;
        end
        if (in_byte_i != ASCII_SPACE) begin
          trim_d = (int'(data_cnt) > TRIM_MAX) ? 7'(TRIM_MAX) : 7'(data_cnt);
        end
      end
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
      head_q <= '0;
      trim_q <= '0;
      pos_q <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (snap_ready_i) begin
        snap_valid_q <= 1'b0;
      end
      if (accept) begin
        if (in_last_i) begin
          hdr_q <= '0;
          head_q <= '0;
          trim_q <= '0;
          pos_q <= '0;
          snap_valid_q <= 1'b1;
        end else begin
          hdr_q <= hdr_d;
          head_q <= head_d;
          trim_q <= trim_d;
          pos_q <= pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_last_i) begin
      snap_q.hdr <= hdr_d;
      snap_q.head <= head_d;
      snap_q.trimmed <= trim_d;
      snap_q.len <= pos_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o = snap_q;

endmodule

@@ src/hed_decode.sv @@
module hed_decode import hed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        snap_valid_i,
  input  packet_t     snap_i,
  output logic        snap_ready_o,
  input  logic [15:0] notify_handle_i,
  input  logic [15:0] command_handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     result_o
);

  logic        advance;
  logic [15:0] conn_q, conn_d;
  logic        sub_q, sub_d;
  logic        led_q, led_d;
  logic        restart;
  kind_e       kind;
  logic        out_valid_q;
  result_t     result_q;
  logic [7:0]  h0, h1;
  logic [15:0] decl_len, attr, desc_val;
  logic [HEAD_LEN-1:0][7:0] folded;
  logic        is_on, is_off, is_toggle;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  assign snap_ready_o = snap_valid_i && (!out_valid_q || out_ready_i);
  assign advance = snap_ready_o;

  assign h0 = snap_i.hdr[0];
  assign h1 = snap_i.hdr[1];
  assign decl_len = (h0 == PKT_EVENT) ? {8'h00, snap_i.hdr[11]}
                                      : {snap_i.hdr[11], snap_i.hdr[10]};
  assign attr = (h0 == PKT_EVENT) ? {snap_i.hdr[8], snap_i.hdr[7]}
                                  : {snap_i.hdr[9], snap_i.hdr[8]};
  assign desc_val = {snap_i.head[1], snap_i.head[0]};

  always_comb begin
    for (int k = 0; k < HEAD_LEN; k++) begin
      folded[k] = fold_upper(snap_i.head[k]);
    end
  end

  assign is_on = snap_i.trimmed == 7'd2 && folded[0] == "O" && folded[1] == "N";
  assign is_off = snap_i.trimmed == 7'd3 && folded[0] == "O" && folded[1] == "F"
                  && folded[2] == "F";
  assign is_toggle = snap_i.trimmed == 7'd6 && folded[0] == "T" && folded[1] == "O"
                     && folded[2] == "G" && folded[3] == "G" && folded[4] == "L"
                     && folded[5] == "E";

  always_comb begin
    conn_d = conn_q;
    sub_d = sub_q;
    led_d = led_q;
    restart = 1'b0;
    kind = KIND_OTHER;
    if (h0 == PKT_EVENT && h1 == EVT_LE_META && int'(snap_i.len) > 4
        && (snap_i.hdr[3] == SUB_CONN || snap_i.hdr[3] == SUB_ENH_CONN)
        && snap_i.hdr[4] == 8'h00) begin
      conn_d = {snap_i.hdr[6], snap_i.hdr[5]};
      sub_d = 1'b0;
      kind = KIND_CONNECTED;
    end else if (h0 == PKT_EVENT && h1 == EVT_DISCONNECT) begin
      conn_d = NOT_LINKED;
      sub_d = 1'b0;
      restart = 1'b1;
      kind = KIND_DISCONNECTED;
    end else if (h1 == EVT_VENDOR && (h0 == PKT_EVENT || h0 == PKT_VENDOR)) begin
      if (int'(snap_i.len) <= HDR_LEN || decl_len == 16'h0000) begin
        kind = KIND_IGNORED;
      end else if (attr == notify_handle_i + 16'd2) begin
        if (desc_val == CCCD_NOTIFY) begin
          sub_d = 1'b1;
          kind = KIND_SUBSCRIBED;
        end else begin
          sub_d = 1'b0;
          kind = KIND_UNSUBSCRIBED;
        end
      end else if (attr == command_handle_i + 16'd1) begin
        if (is_on) begin
          led_d = 1'b1;
          kind = KIND_ON;
        end else if (is_off) begin
          led_d = 1'b0;
          kind = KIND_OFF;
        end else if (is_toggle) begin
          led_d = !led_q;
          kind = KIND_TOGGLE;
        end else begin
          kind = KIND_UNKNOWN;
        end
      end else begin
        kind = KIND_IGNORED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q <= NOT_LINKED;
      sub_q <= 1'b0;
      led_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        conn_q <= conn_d;
        sub_q <= sub_d;
        led_q <= led_d;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q.kind <= kind;
      result_q.led_level <= led_d;
      result_q.link_handle <= conn_d;
      result_q.subscribed <= sub_d;
      result_q.notify_allowed <= (conn_d != NOT_LINKED) && sub_d;
      result_q.restart <= restart;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o = result_q;

endmodule

@@ src/hci_event_command_decoder.sv @@
// Decodes HCI event packets that arrive one byte per transfer, with tlast on the final
// byte, and emits one 24-bit result per packet after the transfer that carries tlast.
// Bytes are taken back to back while the output is not stalled; the packet is captured
// byte by byte, frozen into a snapshot register on its last byte and then classified
// into the output register once that register is free, so packets may follow each
// other without gaps unless the output stalls. Bytes past 64 in a packet are dropped.
// The notify and command characteristic handles are set over the APB port at 0x0 and 0x4.
module hci_event_command_decoder import hed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] event_kind, [4] led_level, [20:5] link_handle, [21] subscribed,
  // [22] notify_allowed, [23] restart_advertising
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] notify_handle_q;
  logic [15:0] command_handle_q;
  logic        snap_valid;
  logic        snap_ready;
  packet_t     snap;
  result_t     result;
  reg_e        reg_sel;

  assign pready = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notify_handle_q <= '0;
      command_handle_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_NOTIFY:  notify_handle_q <= pwdata[15:0];
        REG_COMMAND: command_handle_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NOTIFY:  prdata = {16'h0000, notify_handle_q};
      REG_COMMAND: prdata = {16'h0000, command_handle_q};
      default:     prdata = '0;
    endcase
  end

  hed_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_byte_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .snap_ready_i (snap_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  hed_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_i           (snap),
    .snap_ready_o     (snap_ready),
    .notify_handle_i  (notify_handle_q),
    .command_handle_i (command_handle_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .result_o         (result)
  );

  assign m_axis_tdata = {result.restart, result.notify_allowed, result.subscribed,
                         result.link_handle, result.led_level, result.kind};

endmodule
